[sv/plh_pkg.sv]
// Package for the phone lookahead heuristic block.
// Holds payload, command and status types, register and mode codes, and the clamped add.
// Used by every module of the block but plh_ram.
package plh_pkg;

	localparam int NUM_PHONES  = 64;
	localparam int PHONE_W     = 6;
	localparam int IDX_W       = $clog2(NUM_PHONES);
	localparam int SCORE_W     = 32;
	localparam int MODE_W      = 2;
	localparam int EMIT_W      = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STEPS   = SCORE_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] CFG_HEUR_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMIT_STATES = 1'b1;

	localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AVG       = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FIRST_MAX = 2'd3;

	localparam logic [MODE_W-1:0] MODE_RESET = MODE_MAX;
	localparam logic [EMIT_W-1:0] EMIT_RESET = 4'd3;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [PHONE_W-1:0]        phone;
		logic                      end_mark;
		logic                      first_frame;
	} plh_in_t;

	typedef struct packed {
		logic [PHONE_W-1:0]        phone_out;
		logic signed [SCORE_W-1:0] heuristic;
	} plh_out_t;

	typedef struct packed {
		logic accept;
		logic load_div;
		logic div_step;
		logic fix;
		logic add1;
		logic add2;
		logic commit;
	} plh_cmd_t;

	typedef struct packed {
		logic mode_avg;
		logic mode_first_max;
		logic out_full;
	} plh_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_FIX,
		S_ADD1,
		S_ADD2,
		S_DONE
	} plh_state_t;

	function automatic logic [SCORE_W-1:0] clamp_add(
		input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b
	);
		logic [SCORE_W-1:0] c;
		c = a + b;
		if (a[SCORE_W-1] && b[SCORE_W-1] && !c[SCORE_W-1]) begin
			c = SCORE_MIN;
		end
		return c;
	endfunction

endpackage

[sv/plh_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module plh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/plh_ctrl.sv]
// Sequencer of the phone lookahead heuristic block.
// Issues datapath commands per item; uses plh_pkg types.
module plh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_end,
	input  plh_pkg::plh_stat_t  stat,
	output logic                in_ready,
	output plh_pkg::plh_cmd_t   cmd
);

	plh_pkg::plh_state_t state_q, state_d;
	logic [plh_pkg::DIV_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plh_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			plh_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_end) begin
					state_d = plh_pkg::S_PREP;
				end
			end
			plh_pkg::S_PREP: begin
				if (stat.mode_avg) begin
					cmd.load_div = 1'b1;
					state_d      = plh_pkg::S_DIV;
				end else begin
					state_d = plh_pkg::S_ADD1;
				end
			end
			plh_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == plh_pkg::DIV_CNT_W'(plh_pkg::DIV_STEPS - 1)) begin
					state_d = plh_pkg::S_FIX;
				end
			end
			plh_pkg::S_FIX: begin
				cmd.fix = 1'b1;
				state_d = plh_pkg::S_ADD1;
			end
			plh_pkg::S_ADD1: begin
				cmd.add1 = 1'b1;
				state_d  = stat.mode_first_max ? plh_pkg::S_ADD2 : plh_pkg::S_DONE;
			end
			plh_pkg::S_ADD2: begin
				cmd.add2 = 1'b1;
				state_d  = plh_pkg::S_DONE;
			end
			plh_pkg::S_DONE: begin
				if (!stat.out_full) begin
					cmd.commit = 1'b1;
					state_d    = plh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plh_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[sv/plh_dp.sv]
// Datapath of the phone lookahead heuristic block: config registers, running value,
// radix-16 divider, clamped adder, accumulator RAM and output register. Uses plh_pkg, plh_ram.
module plh_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_en,
	input  logic [plh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  plh_pkg::plh_in_t                in_data,
	input  logic                            out_ready,
	input  plh_pkg::plh_cmd_t               cmd,
	output plh_pkg::plh_stat_t              stat,
	output logic                            out_valid,
	output plh_pkg::plh_out_t               out_data
);

	localparam int W = plh_pkg::SCORE_W;

	logic [plh_pkg::MODE_W-1:0] mode_q, mode_eff;
	logic [plh_pkg::EMIT_W-1:0] emit_q, divisor;
	logic [W-1:0]               running_q, first_q, running_d;
	logic                       at_start_q;
	logic [plh_pkg::PHONE_W-1:0] phone_q;
	logic [plh_pkg::IDX_W-1:0]  idx_q, in_idx;
	logic                       first_frame_q;
	logic [W-1:0]               quo_q, quo_d, acc_q, base, op1, ram_rdata;
	logic [plh_pkg::EMIT_W-1:0] rem_q, rem_d;
	logic                       neg_q;
	logic                       out_full_q;
	plh_pkg::plh_out_t          out_q;
	logic [W-1:0]               score_u;

	assign mode_eff = (mode_q == plh_pkg::MODE_NONE) ? plh_pkg::MODE_MAX : mode_q;
	assign divisor  = (emit_q == '0) ? plh_pkg::EMIT_W'(1) : emit_q;
	assign in_idx   = in_data.phone[plh_pkg::IDX_W-1:0];
	assign score_u  = in_data.score;

	assign stat.mode_avg       = (mode_eff == plh_pkg::MODE_AVG);
	assign stat.mode_first_max = (mode_eff == plh_pkg::MODE_FIRST_MAX);
	assign stat.out_full       = out_full_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= plh_pkg::MODE_RESET;
			emit_q <= plh_pkg::EMIT_RESET;
		end else if (cfg_en) begin
			case (cfg_index)
				plh_pkg::CFG_HEUR_MODE:   mode_q <= cfg_data[plh_pkg::MODE_W-1:0];
				plh_pkg::CFG_EMIT_STATES: emit_q <= cfg_data[plh_pkg::EMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (at_start_q) begin
			running_d = score_u;
		end else if (stat.mode_avg) begin
			running_d = plh_pkg::clamp_add(score_u, running_q);
		end else if ($signed(score_u) > $signed(running_q)) begin
			running_d = score_u;
		end else begin
			running_d = running_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= plh_pkg::SCORE_MIN;
			first_q    <= '0;
			at_start_q <= 1'b1;
		end else if (cmd.accept) begin
			running_q  <= running_d;
			at_start_q <= in_data.end_mark;
			if (at_start_q && stat.mode_first_max) begin
				first_q <= score_u;
			end
		end else if (cmd.commit) begin
			running_q <= plh_pkg::SCORE_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			phone_q       <= in_data.phone;
			idx_q         <= in_idx;
			first_frame_q <= in_data.first_frame;
		end
	end

	always_comb begin
		logic [plh_pkg::EMIT_W:0] t;
		logic [W-1:0]             q;
		logic [plh_pkg::EMIT_W-1:0] r;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < plh_pkg::DIV_BITS; i++) begin
			t = {r, q[W-1]};
			q = {q[W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t    = t - {1'b0, divisor};
				q[0] = 1'b1;
			end
			r = t[plh_pkg::EMIT_W-1:0];
		end
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			neg_q <= running_q[W-1];
			quo_q <= running_q[W-1] ? (~running_q + 1'b1) : running_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end else if (cmd.fix) begin
			quo_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign base = first_frame_q ? '0 : ram_rdata;

	always_comb begin
		if (stat.mode_avg) begin
			op1 = quo_q;
		end else if (stat.mode_first_max) begin
			op1 = first_q;
		end else begin
			op1 = running_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add1) begin
			acc_q <= plh_pkg::clamp_add(base, op1);
		end else if (cmd.add2) begin
			acc_q <= plh_pkg::clamp_add(acc_q, running_q);
		end
	end

	plh_ram #(
		.WIDTH(W),
		.DEPTH(plh_pkg::NUM_PHONES)
	) u_acc_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (idx_q),
		.wdata (acc_q),
		.re    (cmd.accept && in_data.end_mark),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.commit) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.phone_out <= phone_q;
			out_q.heuristic <= acc_q;
		end
	end

	assign out_valid = out_full_q;
	assign out_data  = out_q;

endmodule

[sv/phone_lookahead_heuristic.sv]
// Top level of the phone lookahead heuristic block.
// Joins plh_ctrl, plh_dp (with its plh_ram accumulator store) using plh_pkg types.
//
// Senone scores stream in one per transfer; an item without a phone-end mark leaves the
// block ready for the next one. A phone-end item reads the phone's accumulator, forms the
// per-frame value and writes the updated accumulator back, delivering it as one result;
// in average mode a radix-16 divider (4 quotient bits per cycle) first divides the frame
// sum by the emitting-state count. A held result does not stop new transfers; a phone end
// only waits if the previous result is still untaken when its own is ready. The
// accumulator store needs no clearing: the first_frame mark starts a phone from zero.
// Write configuration only while idle.
module phone_lookahead_heuristic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_en,
	input  logic [plh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  plh_pkg::plh_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output plh_pkg::plh_out_t               out_data
);

	plh_pkg::plh_cmd_t  cmd;
	plh_pkg::plh_stat_t stat;

	plh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_end   (in_data.end_mark),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	plh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_div, cmd.div_step, cmd.fix,
			cmd.add1, cmd.add2, cmd.commit}))
		else $error("more than one datapath command at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result committed over an untaken result");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.end_mark) |=> !in_ready)
		else $error("input taken while a phone end is in progress");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit))
		else $error("result shown without a commit");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for phone_lookahead_heuristic: directed and random senone streams over all modes.
// A scoreboard class predicts each phone-end heuristic and checks results in order.
// Depends on plh_pkg and the phone_lookahead_heuristic RTL.
module tb;
	import plh_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 20;

	class plh_scoreboard;
		logic [MODE_W-1:0]  mode;
		logic [EMIT_W-1:0]  emit;
		logic [SCORE_W-1:0] phone_acc [NUM_PHONES];
		logic [SCORE_W-1:0] run_val;
		logic [SCORE_W-1:0] first_val;
		bit                 phone_start;
		plh_out_t           heur_q [$];
		int                 errors;

		function new();
			mode        = MODE_RESET;
			emit        = EMIT_RESET;
			run_val     = SCORE_MIN;
			first_val   = '0;
			phone_start = 1'b1;
			errors      = 0;
			foreach (phone_acc[i]) phone_acc[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_HEUR_MODE) begin
				mode = data[MODE_W-1:0];
			end else begin
				emit = data[EMIT_W-1:0];
			end
		endfunction

		function logic [SCORE_W-1:0] sat_add(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
			logic [SCORE_W-1:0] c;
			c = a + b;
			if (a[SCORE_W-1] & b[SCORE_W-1] & ~c[SCORE_W-1]) begin
				c = SCORE_MIN;
			end
			return c;
		endfunction

		function void note_score(plh_in_t it);
			logic [MODE_W-1:0]  m;
			logic [SCORE_W-1:0] s;
			logic [SCORE_W-1:0] acc;
			int                 cur;
			int                 best;
			longint             divisor;
			longint             quot;
			plh_out_t           want;
			m    = (mode == MODE_NONE) ? MODE_MAX : mode;
			s    = it.score;
			cur  = s;
			best = run_val;
			if (phone_start) begin
				run_val = s;
				if (m == MODE_FIRST_MAX) first_val = s;
			end else if (m == MODE_AVG) begin
				run_val = sat_add(s, run_val);
			end else if (cur > best) begin
				run_val = s;
			end
			if (!it.end_mark) begin
				phone_start = 1'b0;
				return;
			end
			acc = it.first_frame ? '0 : phone_acc[it.phone];
			case (m)
				MODE_AVG: begin
					divisor = (emit == 0) ? 1 : longint'(emit);
					cur     = run_val;
					quot    = longint'(cur) / divisor;
					acc     = sat_add(acc, quot[SCORE_W-1:0]);
				end
				MODE_FIRST_MAX: begin
					acc = sat_add(sat_add(acc, first_val), run_val);
				end
				default: begin
					acc = sat_add(acc, run_val);
				end
			endcase
			phone_acc[it.phone] = acc;
			run_val             = SCORE_MIN;
			phone_start         = 1'b1;
			want.phone_out      = it.phone;
			want.heuristic      = acc;
			heur_q.push_back(want);
		endfunction

		function void check_heuristic(plh_out_t got);
			plh_out_t want;
			if (heur_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: phone %0d heuristic %0d",
					$time, got.phone_out, got.heuristic);
				return;
			end
			want = heur_q.pop_front();
			if (got.phone_out !== want.phone_out) begin
				errors++;
				$display("%0t: phone_out expected %0d actual %0d",
					$time, want.phone_out, got.phone_out);
			end
			if (got.heuristic !== want.heuristic) begin
				errors++;
				$display("%0t: heuristic of phone %0d expected %0d actual %0d",
					$time, want.phone_out, want.heuristic, got.heuristic);
			end
		endfunction

		function int pending();
			return heur_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	plh_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	plh_out_t              out_data;

	plh_scoreboard sb;
	bit            phone_seen [NUM_PHONES];
	bit            calm;
	bit            hold_req;
	int            sent;

	logic [MODE_W-1:0] rand_mode [8] = '{MODE_AVG, MODE_FIRST_MAX, MODE_MAX, MODE_AVG,
		MODE_NONE, MODE_FIRST_MAX, MODE_AVG, MODE_MAX};
	logic [EMIT_W-1:0] rand_emit [8] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd3, 4'd12, 4'd9};

	phone_lookahead_heuristic dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SCORE_W-1:0] pick_score();
		int r;
		r = $urandom_range(99);
		if (r < 25) return $urandom;
		if (r < 55) return -32'($urandom_range(1000, 1));
		if (r < 75) return SCORE_MIN + $urandom_range(1 << 20);
		if (r < 90) return $urandom_range(1000);
		case ($urandom_range(3))
			0: return SCORE_MIN;
			1: return ~SCORE_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic send_item(input logic [SCORE_W-1:0] score, input int phone,
		input bit last, input bit first);
		plh_in_t it;
		it.score       = score;
		it.phone       = PHONE_W'(phone);
		it.end_mark    = last;
		// start any phone whose accumulator was never written from zero
		it.first_frame = first || (last && !phone_seen[it.phone]);
		if (last) phone_seen[it.phone] = 1'b1;
		while (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_score(it);
		sent++;
	endtask

	task automatic send_phone_run();
		int ph;
		int n;
		bit first;
		ph    = ($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(NUM_PHONES - 1);
		n     = $urandom_range(8, 1);
		first = ($urandom_range(99) < 25);
		for (int k = 0; k < n; k++) begin
			send_item(pick_score(), ph, k == n - 1, first);
		end
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic configure(input logic [MODE_W-1:0] m, input logic [EMIT_W-1:0] e);
		cfg_en    <= 1'b1;
		cfg_index <= CFG_HEUR_MODE;
		cfg_data  <= CFG_DATA_W'(m);
		@(posedge clk);
		sb.set_reg(CFG_HEUR_MODE, CFG_DATA_W'(m));
		cfg_index <= CFG_EMIT_STATES;
		cfg_data  <= e;
		@(posedge clk);
		sb.set_reg(CFG_EMIT_STATES, e);
		cfg_en <= 1'b0;
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) sb.check_heuristic(out_data);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 38);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		int target;
		sb        = new();
		sent      = 0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		cfg_en    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: max mode, positive wrap, negative clamp, phone change
		send_item(~SCORE_MIN, 0, 1, 1);
		send_item(32'sd1, 0, 1, 0);
		send_item(SCORE_MIN, 63, 0, 0);
		send_item(SCORE_MIN, 63, 1, 1);
		send_item('1, 63, 1, 0);
		send_item(32'sd5, 10, 0, 0);
		send_item(32'sd7, 11, 1, 1);

		drain(SETTLE);
		configure(MODE_AVG, 4'd0);
		send_item(SCORE_MIN, 20, 0, 0);
		send_item('1, 20, 1, 1);
		send_item(-32'sd7, 21, 0, 0);
		send_item('0, 21, 1, 1);

		drain(SETTLE);
		configure(MODE_AVG, 4'd15);
		send_item(-32'sd100, 22, 0, 0);
		send_item(-32'sd3, 22, 1, 1);

		drain(SETTLE);
		configure(MODE_FIRST_MAX, 4'd8);
		send_item(-32'sd10, 30, 0, 0);
		send_item(-32'sd2, 30, 0, 0);
		send_item(-32'sd20, 30, 1, 1);
		send_item(SCORE_MIN, 30, 1, 0);

		drain(SETTLE);
		configure(MODE_NONE, 4'd1);
		send_item(32'sd3, 63, 1, 1);
		send_item(~SCORE_MIN, 0, 1, 0);

		for (int p = 0; p < 8; p++) begin
			drain(SETTLE);
			configure(rand_mode[p], rand_emit[p]);
			calm = (p == 3);
			if (p == 1) hold_req = 1'b1;
			target = sent + 62;
			while (sent < target) begin
				if ($urandom_range(99) < 85) begin
					send_phone_run();
				end else begin
					send_item(pick_score(), $urandom_range(NUM_PHONES - 1), 1'b0,
						$urandom_range(1));
				end
			end
		end
		calm = 1'b0;

		drain(30);
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
